// ===== design/assert_macros.svh =====
// assertion macros used by the sampler sequencer wis_seq
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)

`endif

`endif

// ===== design/wis_pkg.sv =====
// types, widths and codes of the weighted index sampler
// no dependencies; used by wis_seq and weighted_index_sampler
package wis_pkg;

	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam int WEIGHT_W = 16;
	localparam int FRAC_W   = 16;
	localparam int TOTAL_W  = 26;
	localparam int INDEX_W  = 10;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	localparam logic MODE_ADD    = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		status_t              status;
		logic [INDEX_W-1:0]   index;
		logic [TOTAL_W-1:0]   total;
	} result_t;

endpackage

// ===== design/wis_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module wis_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/wis_seq.sv =====
// sequencer: table append, target scaling and binary search over the prefix ram
// depends on wis_pkg and assert_macros.svh; drives the ports of one wis_ram
`include "assert_macros.svh"

module wis_seq import wis_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           mode,
	input  logic [WEIGHT_W-1:0]            weight,
	input  logic [FRAC_W-1:0]              random_fraction,
	output logic                           wr_en,
	output logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
	output logic [TOTAL_W-1:0]             wr_data,
	output logic                           rd_en,
	output logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
	input  logic [TOTAL_W-1:0]             rd_data,
	output logic                           res_valid,
	output result_t                        res,
	input  logic                           res_take
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int EXT_W = IDX_W + INDEX_W;
	localparam int PROD_W = TOTAL_W + FRAC_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
	localparam logic [WEIGHT_W-1:0] WMASK = (WEIGHT_BITS >= WEIGHT_W) ?
		{WEIGHT_W{1'b1}} : WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ADDR,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic               mode_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [CNT_W-1:0]   count_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] target_q;
	logic [IDX_W-1:0]   lo_q;
	logic [IDX_W-1:0]   hi_q;
	logic [IDX_W-1:0]   mid_q;
	result_t            res_q;

	logic [TOTAL_W:0]   sum_wide;
	logic [TOTAL_W-1:0] sum_sat;
	logic               full;
	logic [IDX_W-1:0]   mid;
	logic [PROD_W-1:0]  product;
	logic [EXT_W-1:0]   lo_ext;

	assign full     = (count_q >= CNT_MAX);
	assign sum_wide = {1'b0, total_q} + (TOTAL_W + 1)'(weight_q & WMASK);
	assign sum_sat  = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign product  = PROD_W'(total_q) * PROD_W'(frac_q);
	assign lo_ext   = EXT_W'(lo_q);

	assign item_stall = (state_q != ST_IDLE);
	assign res_valid  = (state_q == ST_DONE);
	assign res        = res_q;

	assign wr_en   = (state_q == ST_EXEC) && (mode_q == MODE_ADD) && !full;
	assign wr_addr = count_q[IDX_W-1:0];
	assign wr_data = sum_sat;
	assign rd_en   = (state_q == ST_ADDR) && (lo_q != hi_q);
	assign rd_addr = mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			total_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						mode_q   <= mode;
						weight_q <= weight;
						frac_q   <= random_fraction;
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (mode_q == MODE_ADD) begin
						if (full) begin
							res_q <= '{status: STATUS_FULL, index: '0, total: total_q};
						end else begin
							total_q <= sum_sat;
							count_q <= count_q + 1'b1;
							res_q   <= '{status: STATUS_OK, index: '0, total: sum_sat};
						end
						state_q <= ST_DONE;
					end else if (count_q == '0) begin
						res_q   <= '{status: STATUS_EMPTY, index: '0, total: total_q};
						state_q <= ST_DONE;
					end else if (total_q == '0) begin
						res_q   <= '{status: STATUS_OK, index: '0, total: total_q};
						state_q <= ST_DONE;
					end else begin
						target_q <= product[PROD_W-1:FRAC_W];
						lo_q     <= '0;
						hi_q     <= IDX_W'(count_q - 1'b1);
						state_q  <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					if (lo_q == hi_q) begin
						res_q   <= '{status: STATUS_OK, index: lo_ext[INDEX_W-1:0],
							total: total_q};
						state_q <= ST_DONE;
					end else begin
						mid_q   <= mid;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					// first entry whose inclusive sum exceeds the target
					if (rd_data > target_q) begin
						hi_q <= mid_q;
					end else begin
						lo_q <= mid_q + 1'b1;
					end
					state_q <= ST_ADDR;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_MAX)
	`ASSERT_IMPLIES(a_window_order, clk, arst_n, state_q == ST_ADDR, lo_q <= hi_q)
	`ASSERT_IMPLIES(a_window_in_table, clk, arst_n,
		state_q == ST_ADDR || state_q == ST_CMP, CNT_W'(hi_q) < count_q)
	`ASSERT_IMPLIES(a_mid_in_window, clk, arst_n, state_q == ST_CMP,
		lo_q <= mid_q && mid_q <= hi_q)
	`ASSERT_IMPLIES(a_full_only_at_max, clk, arst_n,
		state_q == ST_DONE && res_q.status == STATUS_FULL, count_q == CNT_MAX)

endmodule

// ===== design/weighted_index_sampler.sv =====
// weighted index sampler top level: prefix ram, sequencer and result register
// depends on wis_pkg, wis_ram and wis_seq
//
// channel  | handshake                 | beat fields
// item     | item_valid, item_stall    | mode, weight, random_fraction
// result   | result_valid, result_stall| status, chosen_index, total_weight
//
// add, empty sample or all-zero sample: after accept ST_EXEC forms the result and ST_DONE
// hands it to the result register; a search sample runs ST_ADDR and ST_CMP for each step
// and a last ST_ADDR, each step split by the registered read of the prefix ram
// the sequencer accepts the next beat only once ST_DONE has handed its result on
// reset clears the entry count and total; the prefix ram is never cleared
// the next item is taken while a result waits in the output register
module weighted_index_sampler import wis_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                mode,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic [FRAC_W-1:0]   random_fraction,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [1:0]          status,
	output logic [INDEX_W-1:0]  chosen_index,
	output logic [TOTAL_W-1:0]  total_weight
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [TOTAL_W-1:0] wr_data;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [TOTAL_W-1:0] rd_data;
	logic               res_valid;
	result_t            res;
	logic               res_take;

	logic               result_valid_q;
	result_t            result_q;

	wis_ram #(
		.WIDTH (TOTAL_W),
		.DEPTH (MAX_ENTRIES)
	) u_prefix_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wis_seq #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.mode            (mode),
		.weight          (weight),
		.random_fraction (random_fraction),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data),
		.res_valid       (res_valid),
		.res             (res),
		.res_take        (res_take)
	);

	assign res_take = res_valid && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = result_q.status;
	assign chosen_index = result_q.index;
	assign total_weight = result_q.total;

endmodule
